// ===== src/k_sorted_stream_sorter_assert.svh =====
// ----------------------------------------------------------------------------
// k_sorted_stream_sorter_assert: assertion macros for the sorter
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef K_SORTED_STREAM_SORTER_ASSERT_SVH
`define K_SORTED_STREAM_SORTER_ASSERT_SVH

// condition must hold on every edge
`define KSSS_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// trigger implies the consequent in the cycle after it
`define KSSS_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ksss_pkg.sv =====
// ----------------------------------------------------------------------------
// ksss_pkg
// Shared types and constants of the k-sorted stream sorter.
// ----------------------------------------------------------------------------
package ksss_pkg;

  localparam int VAL_W = 32;
  localparam int WIN_W = 6;
  // counts up to twice the largest block (64)
  localparam int CNT_W = 7;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    is_last;
  } in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] sorted_value;
    logic                    run_end;
    logic                    sequence_end;
  } out_t;

  typedef enum logic [1:0] {
    S_FILL,
    S_MERGE,
    S_COMMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic             ins_en;
    logic [CNT_W-1:0] fill_cnt;
    logic             mrg_en;
    logic             pick_fill;
    logic             emit;
    logic             run_end;
    logic             seq_end;
    logic [CNT_W-1:0] nh_idx;
    logic             commit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_stall;
    logic fill_less;
  } sts_t;

endpackage

// ===== src/k_sorted_stream_sorter.sv =====
// ----------------------------------------------------------------------------
// k_sorted_stream_sorter
// Sorts a stream in which no value exceeds any value k or more places later.
// ----------------------------------------------------------------------------
// Each request is inserted into a sorted fill row as it is accepted. When the row
// reaches the window length (or a request carries is_last), one comparator
// merges it with the held row, one value per cycle as long as the output side
// takes results, and a commit state follows. No request is taken during the
// merge and commit, so each block passes through its insert, merge and commit
// phases in turn.
// The merge comparator sets the pace. The window register is written through
// the cfg channel, which is always ready.
module k_sorted_stream_sorter #(
  parameter int K_MAX = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  ksss_pkg::in_t              in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output ksss_pkg::out_t             out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [ksss_pkg::WIN_W-1:0] cfg_data
);
  import ksss_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ksss_ctrl #(.K_MAX(K_MAX)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_is_last (in_data.is_last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .sts        (sts),
    .cmd        (cmd)
  );

  ksss_dp #(.K_MAX(K_MAX)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== src/ksss_dp.sv =====
// ----------------------------------------------------------------------------
// ksss_dp
// Datapath: insertion-sorted fill row, held row, new-held row, output register.
// ----------------------------------------------------------------------------
module ksss_dp #(
  parameter int K_MAX = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  ksss_pkg::in_t  in_data,
  input  ksss_pkg::cmd_t cmd,
  output ksss_pkg::sts_t sts,
  output logic           out_valid,
  input  logic           out_ready,
  output ksss_pkg::out_t out_data
);
  import ksss_pkg::*;

  logic signed [VAL_W-1:0] fill_r [K_MAX];
  logic signed [VAL_W-1:0] held_r [K_MAX];
  logic signed [VAL_W-1:0] nh_r   [K_MAX];
  logic [K_MAX-1:0]        gt;
  logic signed [VAL_W-1:0] pick_val;
  logic                    out_valid_r;
  out_t                    out_r;

  // insert position: cells at or above the count, or holding a larger value
  always_comb begin
    for (int i = 0; i < K_MAX; i++) begin
      gt[i] = (CNT_W'(i) >= cmd.fill_cnt) || (in_data.value < fill_r[i]);
    end
  end

  assign pick_val = cmd.pick_fill ? fill_r[0] : held_r[0];

  // fill row: insert on request, pop head when the merge picks it
  always_ff @(posedge clk) begin
    if (cmd.ins_en) begin
      for (int i = 0; i < K_MAX; i++) begin
        if (gt[i]) begin
          if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
            fill_r[i] <= fill_r[(i > 0) ? i - 1 : 0];
          end else begin
            fill_r[i] <= in_data.value;
          end
        end
      end
    end else if (cmd.mrg_en && cmd.pick_fill) begin
      for (int i = 0; i < K_MAX - 1; i++) begin
        fill_r[i] <= fill_r[i+1];
      end
    end
  end

  // held row: pop head when the merge picks it, reload from new-held row on commit
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      for (int i = 0; i < K_MAX; i++) begin
        held_r[i] <= nh_r[i];
      end
    end else if (cmd.mrg_en && !cmd.pick_fill) begin
      for (int i = 0; i < K_MAX - 1; i++) begin
        held_r[i] <= held_r[i+1];
      end
    end
  end

  // new-held row: upper merged values
  always_ff @(posedge clk) begin
    for (int i = 0; i < K_MAX; i++) begin
      if (cmd.mrg_en && !cmd.emit && cmd.nh_idx == CNT_W'(i)) begin
        nh_r[i] <= pick_val;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.mrg_en && cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mrg_en && cmd.emit) begin
      out_r.sorted_value <= pick_val;
      out_r.run_end      <= cmd.run_end;
      out_r.sequence_end <= cmd.seq_end;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_r;
  assign sts.out_stall = out_valid_r && !out_ready;
  assign sts.fill_less = fill_r[0] < held_r[0];

endmodule

// ===== src/ksss_ctrl.sv =====
// ----------------------------------------------------------------------------
// ksss_ctrl
// Controller: window register, block counts and merge sequencing.
// ----------------------------------------------------------------------------
module ksss_ctrl #(
  parameter int K_MAX = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_is_last,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [ksss_pkg::WIN_W-1:0] cfg_data,
  input  ksss_pkg::sts_t            sts,
  output ksss_pkg::cmd_t            cmd
);
  import ksss_pkg::*;

  state_t             state_r, state_nxt;
  logic [WIN_W-1:0]   window_r;
  logic [CNT_W-1:0]   hc_r, hc_nxt;
  logic [CNT_W-1:0]   fc_r, fc_nxt;
  logic [CNT_W-1:0]   a_rem_r, a_rem_nxt;
  logic [CNT_W-1:0]   b_rem_r, b_rem_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   emit_r, emit_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic               last_r, last_nxt;
  logic [CNT_W-1:0]   blen;
  logic [CNT_W-1:0]   fc_inc;
  logic               accept, close, emitting, step, pick_fill;

  // effective block length
  always_comb begin
    priority if (window_r == '0) begin
      blen = CNT_W'(1);
    end else if (CNT_W'(window_r) > CNT_W'(K_MAX)) begin
      blen = CNT_W'(K_MAX);
    end else begin
      blen = CNT_W'(window_r);
    end
  end

  assign accept    = in_valid && in_ready;
  assign fc_inc    = (fc_r < CNT_W'(K_MAX)) ? fc_r + CNT_W'(1) : fc_r;
  assign close     = in_is_last || (fc_inc >= blen);
  assign emitting  = idx_r < emit_r;
  assign step      = (state_r == S_MERGE) && !(emitting && sts.out_stall);
  assign pick_fill = (b_rem_r != '0) && ((a_rem_r == '0) || sts.fill_less);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_FILL:   if (accept && close) state_nxt = S_MERGE;
      S_MERGE:  if (step && idx_r == n_r - CNT_W'(1)) state_nxt = S_COMMIT;
      S_COMMIT: state_nxt = S_FILL;
      default:  state_nxt = S_FILL;
    endcase
  end

  // counters
  always_comb begin
    hc_nxt    = hc_r;
    fc_nxt    = fc_r;
    a_rem_nxt = a_rem_r;
    b_rem_nxt = b_rem_r;
    idx_nxt   = idx_r;
    emit_nxt  = emit_r;
    n_nxt     = n_r;
    last_nxt  = last_r;
    unique case (state_r)
      S_FILL: begin
        if (accept) begin
          fc_nxt = fc_inc;
          if (close) begin
            a_rem_nxt = hc_r;
            b_rem_nxt = fc_inc;
            n_nxt     = hc_r + fc_inc;
            emit_nxt  = in_is_last ? hc_r + fc_inc : hc_r;
            idx_nxt   = '0;
            last_nxt  = in_is_last;
          end
        end
      end
      S_MERGE: begin
        if (step) begin
          idx_nxt = idx_r + CNT_W'(1);
          if (pick_fill) b_rem_nxt = b_rem_r - CNT_W'(1);
          else           a_rem_nxt = a_rem_r - CNT_W'(1);
        end
      end
      S_COMMIT: begin
        hc_nxt = last_r ? '0 : n_r - emit_r;
        fc_nxt = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_FILL;
      window_r <= WIN_W'(32);
      hc_r     <= '0;
      fc_r     <= '0;
      a_rem_r  <= '0;
      b_rem_r  <= '0;
      idx_r    <= '0;
      emit_r   <= '0;
      n_r      <= '0;
      last_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) window_r <= cfg_data;
      hc_r    <= hc_nxt;
      fc_r    <= fc_nxt;
      a_rem_r <= a_rem_nxt;
      b_rem_r <= b_rem_nxt;
      idx_r   <= idx_nxt;
      emit_r  <= emit_nxt;
      n_r     <= n_nxt;
      last_r  <= last_nxt;
    end
  end

  // outputs
  always_comb begin
    in_ready      = 1'b0;
    cfg_ready     = 1'b1;
    cmd.ins_en    = 1'b0;
    cmd.fill_cnt  = fc_r;
    cmd.mrg_en    = 1'b0;
    cmd.pick_fill = pick_fill;
    cmd.emit      = emitting;
    cmd.run_end   = idx_r == emit_r - CNT_W'(1);
    cmd.seq_end   = last_r && (idx_r == emit_r - CNT_W'(1));
    cmd.nh_idx    = idx_r - emit_r;
    cmd.commit    = 1'b0;
    unique case (state_r)
      S_FILL: begin
        in_ready   = 1'b1;
        cmd.ins_en = in_valid;
      end
      S_MERGE:  cmd.mrg_en = step;
      S_COMMIT: cmd.commit = 1'b1;
      default: ;
    endcase
  end

  `include "k_sorted_stream_sorter_assert.svh"

  `KSSS_ASSERT(a_rem_sum, state_r != S_MERGE || a_rem_r + b_rem_r == n_r - idx_r, "bad count")
  `KSSS_ASSERT(a_idx_rng, state_r != S_MERGE || idx_r < n_r, "merge index overrun")
  `KSSS_ASSERT(a_no_stall, !(cmd.mrg_en && cmd.emit && sts.out_stall), "emit while stalled")
  `KSSS_ASSERT_NEXT(a_commit, state_r == S_COMMIT, state_r == S_FILL && fc_r == '0, "commit exit")

endmodule
